// ===== rtl/secp256k1_field_alu_macros.svh =====
// ----------------------------------------------------------------------------
// secp256k1 field ALU assertion macros
// Shared property wrappers for the field ALU checks.
// ----------------------------------------------------------------------------
`ifndef SECP256K1_FIELD_ALU_MACROS_SVH
`define SECP256K1_FIELD_ALU_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SFA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("field alu check failed");

// next-cycle implication, clocked on clk, off during reset
`define SFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("field alu check failed");

`endif

// ===== rtl/sfa_pkg.sv =====
// ----------------------------------------------------------------------------
// sfa_pkg
// Types and constants for the secp256k1 field ALU.
// ----------------------------------------------------------------------------
package sfa_pkg;

  // field prime p = 2^256 - 2^32 - 977
  localparam logic [255:0] FIELD_P =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
  // 2^256 mod p
  localparam logic [255:0] WRAP_K = 256'h1_000003D1;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_INV = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARITH,
    ST_REDUCE,
    ST_MUL_DBL,
    ST_MUL_ADD,
    ST_INV
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] a_limb0;
    logic [63:0] a_limb1;
    logic [63:0] a_limb2;
    logic [63:0] a_limb3;
    logic [63:0] b_limb0;
    logic [63:0] b_limb1;
    logic [63:0] b_limb2;
    logic [63:0] b_limb3;
  } in_t;

  typedef struct packed {
    logic [63:0] r_limb0;
    logic [63:0] r_limb1;
    logic [63:0] r_limb2;
    logic [63:0] r_limb3;
  } out_t;

endpackage

// ===== rtl/secp256k1_field_alu.sv =====
// ----------------------------------------------------------------------------
// secp256k1_field_alu
// Add, subtract, multiply and invert over the secp256k1 prime field.
// ----------------------------------------------------------------------------
//  channel | ports                   | transfer
//  --------+-------------------------+-------------------------------------
//  input   | start, busy, in_data    | edge with start high and busy low
//  result  | out_valid, out_data     | edge ending the one-cycle strobe
//
// Add and subtract compute in ST_ARITH, which registers the result and the
// strobe. Multiply runs a shift-and-add over 256 multiplier bits, one
// modular double and one modular add per bit. Invert runs a binary extended
// gcd, one halving or one subtract step per cycle. Synchronous reset returns
// the sequencer to idle. The receiver cannot stall; busy stays high from
// transfer until the cycle the strobe is shown.
module secp256k1_field_alu (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sfa_pkg::in_t  in_data,
  output logic          out_valid,
  output sfa_pkg::out_t out_data
);
  import sfa_pkg::*;

  state_t       state_r, state_nxt;
  cmd_t         cmd_r, cmd_nxt;
  logic [255:0] a_r, a_nxt;     // operand a, multiplier, or u
  logic [255:0] b_r, b_nxt;     // operand b, multiplicand, or v
  logic [255:0] acc_r, acc_nxt; // product or x1
  logic [255:0] x2_r, x2_nxt;
  logic [7:0]   cnt_r, cnt_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [255:0] res_r, res_nxt;

  logic [256:0] a_sp, b_sp;
  logic [255:0] a_red, b_red;
  logic [256:0] sum, sum_sp, dif;
  logic [255:0] add_res, sub_res;
  logic [256:0] dbl, dbl_sp, ms, ms_sp;
  logic [255:0] dbl_res, madd_res;
  logic [256:0] uv, vu, sd, hs;
  logic         u_ge_v;
  logic [255:0] sx, sy, smod, hx, hres;
  logic         u_zero, u_one, v_one;

  // operand reduction below p
  assign a_sp  = {1'b0, a_r} - {1'b0, FIELD_P};
  assign b_sp  = {1'b0, b_r} - {1'b0, FIELD_P};
  assign a_red = a_sp[256] ? a_r : a_sp[255:0];
  assign b_red = b_sp[256] ? b_r : b_sp[255:0];

  // add / subtract with one correction
  assign sum     = {1'b0, a_r} + {1'b0, b_r};
  assign sum_sp  = sum - {1'b0, FIELD_P};
  assign add_res = sum[256] ? (sum[255:0] + WRAP_K)
                 : (sum_sp[256] ? sum[255:0] : sum_sp[255:0]);
  assign dif     = {1'b0, a_r} - {1'b0, b_r};
  assign sub_res = dif[256] ? (dif[255:0] + FIELD_P) : dif[255:0];

  // multiply steps
  assign dbl      = {acc_r, 1'b0};
  assign dbl_sp   = dbl - {1'b0, FIELD_P};
  assign dbl_res  = dbl_sp[256] ? dbl[255:0] : dbl_sp[255:0];
  assign ms       = {1'b0, acc_r} + {1'b0, b_r};
  assign ms_sp    = ms - {1'b0, FIELD_P};
  assign madd_res = ms_sp[256] ? ms[255:0] : ms_sp[255:0];

  // inverse steps
  assign uv     = {1'b0, a_r} - {1'b0, b_r};
  assign vu     = {1'b0, b_r} - {1'b0, a_r};
  assign u_ge_v = !uv[256];
  assign sx     = u_ge_v ? acc_r : x2_r;
  assign sy     = u_ge_v ? x2_r : acc_r;
  assign sd     = {1'b0, sx} - {1'b0, sy};
  assign smod   = sd[256] ? (sd[255:0] + FIELD_P) : sd[255:0];
  assign hx     = !a_r[0] ? acc_r : x2_r;
  assign hs     = {1'b0, hx} + (hx[0] ? {1'b0, FIELD_P} : 257'd0);
  assign hres   = hs[256:1];
  assign u_zero = (a_r == 256'd0);
  assign u_one  = (a_r == 256'd1);
  assign v_one  = (b_r == 256'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_data.cmd == CMD_ADD || in_data.cmd == CMD_SUB) begin
            state_nxt = ST_ARITH;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_ARITH:   state_nxt = ST_IDLE;
      ST_REDUCE:  state_nxt = (cmd_r == CMD_MUL) ? ST_MUL_DBL : ST_INV;
      ST_MUL_DBL: state_nxt = ST_MUL_ADD;
      ST_MUL_ADD: state_nxt = (cnt_r == 8'hFF) ? ST_IDLE : ST_MUL_DBL;
      ST_INV: begin
        if (u_zero || u_one || v_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt       = cmd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    x2_nxt        = x2_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt = in_data.cmd;
          a_nxt   = {in_data.a_limb3, in_data.a_limb2, in_data.a_limb1, in_data.a_limb0};
          b_nxt   = {in_data.b_limb3, in_data.b_limb2, in_data.b_limb1, in_data.b_limb0};
        end
      end
      ST_ARITH: begin
        res_nxt       = (cmd_r == CMD_ADD) ? add_res : sub_res;
        out_valid_nxt = 1'b1;
      end
      ST_REDUCE: begin
        a_nxt   = a_red;
        b_nxt   = (cmd_r == CMD_MUL) ? b_red : FIELD_P;
        acc_nxt = (cmd_r == CMD_MUL) ? 256'd0 : 256'd1;
        x2_nxt  = 256'd0;
        cnt_nxt = 8'd0;
      end
      ST_MUL_DBL: begin
        acc_nxt = dbl_res;
      end
      ST_MUL_ADD: begin
        if (a_r[255]) begin
          acc_nxt = madd_res;
        end
        a_nxt   = {a_r[254:0], 1'b0};
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == 8'hFF) begin
          res_nxt       = a_r[255] ? madd_res : acc_r;
          out_valid_nxt = 1'b1;
        end
      end
      ST_INV: begin
        if (u_zero) begin
          res_nxt       = 256'd0;
          out_valid_nxt = 1'b1;
        end else if (u_one) begin
          res_nxt       = acc_r;
          out_valid_nxt = 1'b1;
        end else if (v_one) begin
          res_nxt       = x2_r;
          out_valid_nxt = 1'b1;
        end else if (!a_r[0]) begin
          a_nxt   = {1'b0, a_r[255:1]};
          acc_nxt = hres;
        end else if (!b_r[0]) begin
          b_nxt  = {1'b0, b_r[255:1]};
          x2_nxt = hres;
        end else if (u_ge_v) begin
          a_nxt   = uv[255:0];
          acc_nxt = smod;
        end else begin
          b_nxt  = vu[255:0];
          x2_nxt = smod;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    x2_r  <= x2_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = '{r_limb0: res_r[63:0],    r_limb1: res_r[127:64],
                       r_limb2: res_r[191:128], r_limb3: res_r[255:192]};

`include "secp256k1_field_alu_macros.svh"

  `SFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SFA_ASSERT_SAME(a_strobe_idle, out_valid, !busy)
  `SFA_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks add, subtract, multiply and invert of the secp256k1 field ALU
// against a wide-integer predictor, with directed corner operands and random
// traffic under several start-gap profiles.
// ----------------------------------------------------------------------------
module tb_top;
  import sfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  out_t        pending_results[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned idle_pct;

  secp256k1_field_alu i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [255:0] field_mul(logic [255:0] x, logic [255:0] y);
    logic [511:0] prod;
    prod = {256'd0, x} * {256'd0, y};
    return 256'(prod % {256'd0, FIELD_P});
  endfunction

  function automatic logic [255:0] field_inv(logic [255:0] x);
    logic [255:0] acc;
    logic [255:0] expo;
    acc = 256'd1;
    expo = FIELD_P - 256'd2;
    for (int i = 255; i >= 0; i--) begin
      acc = field_mul(acc, acc);
      if (expo[i]) begin
        acc = field_mul(acc, x);
      end
    end
    return acc;
  endfunction

  function automatic out_t field_result(in_t item);
    logic [255:0] a;
    logic [255:0] b;
    logic [256:0] sum;
    logic [255:0] r;
    out_t         res;
    a = {item.a_limb3, item.a_limb2, item.a_limb1, item.a_limb0};
    b = {item.b_limb3, item.b_limb2, item.b_limb1, item.b_limb0};
    case (item.cmd)
      CMD_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        if (sum[256]) begin
          r = sum[255:0] + WRAP_K;
        end else if (sum[255:0] >= FIELD_P) begin
          r = sum[255:0] - FIELD_P;
        end else begin
          r = sum[255:0];
        end
      end
      CMD_SUB: begin
        r = a - b;
        if (a < b) begin
          r = r + FIELD_P;
        end
      end
      CMD_MUL: r = field_mul(a, b);
      default: r = field_inv(a);
    endcase
    res.r_limb0 = r[63:0];
    res.r_limb1 = r[127:64];
    res.r_limb2 = r[191:128];
    res.r_limb3 = r[255:192];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("tb_top: mismatch %s got %h want %h", what, got, want);
    error_count++;
  endtask

  // check each strobed result against the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected r_limb0", out_data.r_limb0, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.r_limb0 !== want.r_limb0) begin
          report_mismatch("r_limb0", out_data.r_limb0, want.r_limb0);
        end
        if (out_data.r_limb1 !== want.r_limb1) begin
          report_mismatch("r_limb1", out_data.r_limb1, want.r_limb1);
        end
        if (out_data.r_limb2 !== want.r_limb2) begin
          report_mismatch("r_limb2", out_data.r_limb2, want.r_limb2);
        end
        if (out_data.r_limb3 !== want.r_limb3) begin
          report_mismatch("r_limb3", out_data.r_limb3, want.r_limb3);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: timeout");
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // hold start high until the transfer, then optionally idle
  task automatic send_op(cmd_t cmd, logic [255:0] a, logic [255:0] b);
    in_t item;
    int unsigned gap;
    item.cmd = cmd;
    {item.a_limb3, item.a_limb2, item.a_limb1, item.a_limb0} = a;
    {item.b_limb3, item.b_limb2, item.b_limb1, item.b_limb0} = b;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    do begin
      @(posedge clk);
    end while (busy);
    pending_results.push_back(field_result(item));
    gap = 0;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 8);
    end
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic logic [255:0] rand_operand();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) begin
      v[i*32 +: 32] = $urandom;
    end
    case ($urandom_range(9))
      0: v = 256'($urandom_range(0, 1000));
      1: v = FIELD_P - 256'($urandom_range(1, 1000));
      2: v = ~256'd0 - 256'($urandom_range(0, 1000));
      3: v = FIELD_P + 256'($urandom_range(0, 976));
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_add_corners();
    send_op(CMD_ADD, 256'd0, 256'd0);
    send_op(CMD_ADD, FIELD_P - 1, 256'd1);
    send_op(CMD_ADD, FIELD_P - 1, FIELD_P - 1);
    send_op(CMD_ADD, ~256'd0, ~256'd0);
    send_op(CMD_ADD, FIELD_P, 256'd0);
  endtask

  task automatic test_sub_corners();
    send_op(CMD_SUB, 256'd0, 256'd1);
    send_op(CMD_SUB, ~256'd0, 256'd0);
    send_op(CMD_SUB, 256'd0, ~256'd0);
    send_op(CMD_SUB, FIELD_P - 1, FIELD_P - 1);
  endtask

  task automatic test_mul_corners();
    send_op(CMD_MUL, ~256'd0, ~256'd0);
    send_op(CMD_MUL, FIELD_P - 1, FIELD_P - 1);
    send_op(CMD_MUL, 256'd0, ~256'd0);
    send_op(CMD_MUL, FIELD_P, 256'd5);
    send_op(CMD_MUL, 256'd1, FIELD_P - 1);
  endtask

  // inverse of zero and of p both give zero
  task automatic test_inv_corners();
    send_op(CMD_INV, 256'd0, ~256'd0);
    send_op(CMD_INV, FIELD_P, 256'd0);
    send_op(CMD_INV, 256'd1, 256'd0);
    send_op(CMD_INV, FIELD_P - 1, 256'd0);
    send_op(CMD_INV, ~256'd0, 256'd0);
    send_op(CMD_INV, 256'd2, 256'd0);
  endtask

  task automatic test_random_ops(int unsigned count, int unsigned pct);
    idle_pct = pct;
    repeat (count) begin
      send_op(cmd_t'($urandom_range(3)), rand_operand(), rand_operand());
    end
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    idle_pct    = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_add_corners();
    test_sub_corners();
    test_mul_corners();
    test_inv_corners();
    test_random_ops(240, 0);
    test_random_ops(230, 88);
    test_random_ops(230, 34);

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
